// File: src/bdfsu_pkg.sv
// shared types and constant tables for the bdf state update block
// no dependencies
package bdfsu_pkg;

  // field widths and other sizes
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ORD_W   = 3;
  localparam int unsigned TERMS   = 6;
  localparam int unsigned ORDERS  = 5;
  localparam int unsigned NDIV_STEPS = 16;
  localparam int unsigned RDIV_STEPS = 32;

  // register indexes on the config port
  localparam logic REG_STEP_SIZE = 1'b0;
  localparam logic REG_TOLERANCE = 1'b1;

  // formula weights per order: c0..c4, weight of h*f
  localparam logic signed [9:0] BDF_COEF [ORDERS][TERMS] = '{
    '{10'sd1,   10'sd0,    10'sd0,   10'sd0,   10'sd0,  10'sd1},
    '{10'sd4,   -10'sd1,   10'sd0,   10'sd0,   10'sd0,  10'sd2},
    '{10'sd18,  -10'sd9,   10'sd2,   10'sd0,   10'sd0,  10'sd6},
    '{10'sd48,  -10'sd36,  10'sd16,  -10'sd3,  10'sd0,  10'sd12},
    '{10'sd300, -10'sd300, 10'sd200, -10'sd75, 10'sd12, 10'sd60}
  };

  // divisor per order
  localparam logic [7:0] BDF_DIV [ORDERS] = '{8'd1, 8'd3, 8'd11, 8'd25, 8'd137};

  // unity in unsigned q16.16
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load;
    logic       mul_h;
    logic       acc_en;
    logic [2:0] acc_idx;
    logic       ndiv_init;
    logic       ndiv_step;
    logic       newv_calc;
    logic       err_calc;
    logic       tol_calc;
    logic       rdiv_init;
    logic       rdiv_step;
    logic       out_load;
  } bdfsu_cmd_t;

endpackage

// File: src/bdfsu_ctrl.sv
// sequencer for one element update: accept, products, divisions, output
// depends on bdfsu_pkg
module bdfsu_ctrl
  import bdfsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output bdfsu_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_MULH, S_ACC, S_NINIT, S_NDIV, S_NEWV, S_ERR, S_TOL, S_RINIT, S_RDIV, S_DONE
  } state_t;

  state_t     state;
  logic [4:0] cnt;
  logic       s_fire;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.load      = s_fire;
    cmd.mul_h     = (state == S_MULH);
    cmd.acc_en    = (state == S_ACC);
    cmd.acc_idx   = cnt[2:0];
    cmd.ndiv_init = (state == S_NINIT);
    cmd.ndiv_step = (state == S_NDIV);
    cmd.newv_calc = (state == S_NEWV);
    cmd.err_calc  = (state == S_ERR);
    cmd.tol_calc  = (state == S_TOL);
    cmd.rdiv_init = (state == S_RINIT);
    cmd.rdiv_step = (state == S_RDIV);
    cmd.out_load  = (state == S_DONE) && out_free;
  end

  // state, step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE:  if (s_fire) state <= S_MULH;
        S_MULH: begin
          state <= S_ACC;
          cnt   <= '0;
        end
        S_ACC: begin
          if (cnt == 5'(TERMS - 1)) begin
            state <= S_NINIT;
            cnt   <= '0;
          end else cnt <= cnt + 5'd1;
        end
        S_NINIT: state <= S_NDIV;
        S_NDIV: begin
          if (cnt == 5'(NDIV_STEPS - 1)) begin
            state <= S_NEWV;
            cnt   <= '0;
          end else cnt <= cnt + 5'd1;
        end
        S_NEWV:  state <= S_ERR;
        S_ERR:   state <= S_TOL;
        S_TOL:   state <= S_RINIT;
        S_RINIT: begin
          state <= S_RDIV;
          cnt   <= '0;
        end
        S_RDIV: begin
          if (cnt == 5'(RDIV_STEPS - 1)) begin
            state <= S_DONE;
            cnt   <= '0;
          end else cnt <= cnt + 5'd1;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an accepted item always starts the h*f product next
  a_start: assert property (@(posedge clk) disable iff (rst) s_fire |=> cmd.mul_h)
    else $error("accept not followed by product step");
  // output only loaded when the register is free
  a_load: assert property (@(posedge clk) disable iff (rst) cmd.out_load |-> out_free)
    else $error("output overwritten while held");
  // a new result only appears after an output load
  a_valid: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.out_load))
    else $error("result shown without load");

endmodule

// File: src/bdfsu_datapath.sv
// datapath: weighted sum, division by order divisor, error ratio divider
// depends on bdfsu_pkg
module bdfsu_datapath
  import bdfsu_pkg::*;
#(
  parameter int unsigned ORDER_CAP   = 5,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  bdfsu_cmd_t       cmd,
  input  logic             cfg_wr_en,
  input  logic             cfg_addr,
  input  logic [31:0]      cfg_wdata,
  input  logic [ORD_W-1:0] in_order,
  input  logic [VAL_W-1:0] in_hist [ORDERS],
  input  logic [VAL_W-1:0] in_deriv,
  input  logic [VAL_W-1:0] in_prior,
  input  logic             in_last,
  output logic [VAL_W-1:0] new_value,
  output logic [VAL_W-1:0] exceedance_max,
  output logic             converged,
  output logic             end_of_vector
);

  localparam int unsigned MAXO = (ORDER_CAP > 5) ? 5 : ((ORDER_CAP < 1) ? 1 : ORDER_CAP);
  localparam int unsigned VW   = (VALUE_WIDTH > 32) ? 32 : ((VALUE_WIDTH < 2) ? 2 : VALUE_WIDTH);
  localparam logic signed [63:0] HMAX = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [63:0] HMIN = -HMAX - 64'sd1;

  logic [31:0]        step_size, tolerance, ratio_max;
  logic [2:0]         ord_idx;
  logic [VAL_W-1:0]   hist [ORDERS];
  logic [VAL_W-1:0]   deriv, prior;
  logic               last;
  logic [63:0]        prod_h;
  logic signed [63:0] acc;
  logic [63:0]        dq;
  logic [7:0]         dr;
  logic               dneg;
  logic signed [31:0] newv;
  logic [48:0]        err_q;
  logic [63:0]        sprod;
  logic [63:0]        tol;
  logic [63:0]        rr;
  logic [31:0]        rq;
  logic               rsat;

  // effective order index
  logic [2:0] ord_c;
  always_comb begin
    ord_c = in_order;
    if (ord_c == 3'd0) ord_c = 3'd1;
    if (ord_c > 3'(MAXO)) ord_c = 3'(MAXO);
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= ONE_Q16;
      tolerance <= 32'd4;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_STEP_SIZE: step_size <= cfg_wdata;
        REG_TOLERANCE: tolerance <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // operand of the current term
  logic               fneg;
  logic [31:0]        fmag;
  logic [47:0]        pmag;
  logic signed [48:0] operand;
  logic signed [58:0] term;
  assign fneg = deriv[31];
  assign fmag = fneg ? (32'd0 - deriv) : deriv;
  assign pmag = prod_h[63:16];
  always_comb begin
    if (cmd.acc_idx < 3'(ORDERS))
      operand = 49'(signed'(hist[cmd.acc_idx[2:0] > 3'd4 ? 3'd4 : cmd.acc_idx]));
    else
      operand = fneg ? -signed'({1'b0, pmag}) : signed'({1'b0, pmag});
    term = BDF_COEF[ord_idx][cmd.acc_idx > 3'd5 ? 3'd5 : cmd.acc_idx] * operand;
  end

  // radix-16 step of the numerator division
  logic [7:0]  dv;
  logic [7:0]  r_n;
  logic [3:0]  qb;
  logic [8:0]  r9;
  assign dv = BDF_DIV[ord_idx];
  always_comb begin
    r_n = dr;
    qb  = '0;
    for (int i = 0; i < 4; i++) begin
      r9 = {r_n, dq[63 - i]};
      if (r9 >= {1'b0, dv}) begin
        r9 = r9 - {1'b0, dv};
        qb[3 - i] = 1'b1;
      end
      r_n = r9[7:0];
    end
  end

  // signed quotient and saturation
  logic signed [63:0] qs;
  assign qs = dneg ? -signed'(dq) : signed'(dq);

  // error terms
  logic signed [32:0] diff, sum;
  logic [32:0]        emag, smag;
  logic [31:0]        eps;
  assign diff = 33'(signed'(prior)) - 33'(newv);
  assign sum  = 33'(signed'(prior)) + 33'(newv);
  assign emag = diff[32] ? (33'd0 - diff) : diff;
  assign smag = sum[32] ? (33'd0 - sum) : sum;
  assign eps  = (tolerance == 32'd0) ? 32'd1 : tolerance;

  // ratio divider step
  logic [64:0] r2;
  assign r2 = {rr, 1'b0};

  // final ratio and running maximum
  logic [31:0] ratio, rm;
  assign ratio = rsat ? 32'hFFFF_FFFF : rq;
  assign rm    = (ratio > ratio_max) ? ratio : ratio_max;

  always_ff @(posedge clk) begin
    if (rst) ratio_max <= '0;
    else if (cmd.out_load) ratio_max <= last ? 32'd0 : rm;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ord_idx <= ord_c - 3'd1;
      hist    <= in_hist;
      deriv   <= in_deriv;
      prior   <= in_prior;
      last    <= in_last;
      acc     <= '0;
    end
    if (cmd.mul_h) prod_h <= fmag * step_size;
    if (cmd.acc_en) acc <= acc + 64'(term);
    if (cmd.ndiv_init) begin
      dneg <= acc[63];
      dq   <= acc[63] ? (64'd0 - acc) : acc;
      dr   <= '0;
    end
    if (cmd.ndiv_step) begin
      dq <= {dq[59:0], qb};
      dr <= r_n;
    end
    if (cmd.newv_calc) begin
      if (qs > HMAX) newv <= HMAX[31:0];
      else if (qs < HMIN) newv <= HMIN[31:0];
      else newv <= qs[31:0];
    end
    if (cmd.err_calc) begin
      err_q <= {emag[32:0], 16'd0};
      sprod <= 64'({31'd0, smag} * {32'd0, eps});
    end
    if (cmd.tol_calc) tol <= {16'd0, eps, 16'd0} + {1'b0, sprod[63:1]};
    if (cmd.rdiv_init) begin
      rsat <= {15'd0, err_q} >= tol;
      rr   <= {15'd0, err_q};
      rq   <= '0;
    end
    if (cmd.rdiv_step) begin
      if (r2 >= {1'b0, tol}) begin
        rr <= 64'(r2 - {1'b0, tol});
        rq <= {rq[30:0], 1'b1};
      end else begin
        rr <= r2[63:0];
        rq <= {rq[30:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      new_value      <= newv;
      exceedance_max <= rm;
      converged      <= last && (rm <= ONE_Q16);
      end_of_vector  <= last;
    end
  end

endmodule

// File: src/bdf_state_update_with_error_max.sv
// top level of the bdf state update block with running error maximum
// depends on bdfsu_pkg, bdfsu_ctrl and bdfsu_datapath
//
// Usage: one input item per state element on the s_ side. The block forms
// the new value by the backward differentiation formula of the item's order
// and updates the running maximum of the relative error against the prior
// iterate. One result item per input item leaves on the m_ side; tlast
// marks the final element, on which converged is valid and the maximum is
// cleared. step_size and tolerance are to be written on the cfg port only while idle; the block does not enforce this.
// Timing: an item passes the h*f product, the weighted sum, the 16-step
// numerator divider, the error terms and the 32-step serial divider for the
// error ratio; the next item is taken in the cycle after the result is loaded.
// The result waits in an output register; while the receiver stalls the
// block finishes the current item and then holds in its last step.
// Reset (rst, synchronous) sets step_size to 1.0, tolerance to 4 and the
// running maximum to zero, and empties the output register.
module bdf_state_update_with_error_max
  import bdfsu_pkg::*;
#(
  parameter int unsigned ORDER_CAP   = 5,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic         cfg_addr,
  input  logic [31:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // order, hist_0, hist_1, hist_2, hist_3, hist_4, derivative, prior_iterate
  input  logic [231:0] s_tdata,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_value, exceedance_max, converged
  output logic [71:0]  m_tdata,
  output logic         m_tlast
);

  bdfsu_cmd_t       cmd;
  logic [VAL_W-1:0] hist [ORDERS];
  logic [VAL_W-1:0] new_value, exceedance_max;
  logic             converged;

  // unpack history fields
  always_comb begin
    for (int i = 0; i < ORDERS; i++) hist[i] = s_tdata[3 + 32*i +: 32];
  end

  bdfsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  bdfsu_datapath #(
    .ORDER_CAP   (ORDER_CAP),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_order       (s_tdata[2:0]),
    .in_hist        (hist),
    .in_deriv       (s_tdata[194:163]),
    .in_prior       (s_tdata[226:195]),
    .in_last        (s_tlast),
    .new_value      (new_value),
    .exceedance_max (exceedance_max),
    .converged      (converged),
    .end_of_vector  (m_tlast)
  );

  // pack result
  assign m_tdata = {7'd0, converged, exceedance_max, new_value};

endmodule
